// ===== rtl/dlps_pkg.sv =====
package dlps_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEASE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ID     = 3'd4;

  localparam logic [1:0] KIND_DIS = 2'd0;
  localparam logic [1:0] KIND_REQ = 2'd1;

  localparam logic [1:0] REPLY_OFR = 2'd0;
  localparam logic [1:0] REPLY_NAK = 2'd1;
  localparam logic [1:0] REPLY_ACK = 2'd2;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_PEND = 2'd1;
  localparam logic [1:0] ST_OCC  = 2'd2;
  localparam logic [1:0] ST_EXP  = 2'd3;

  localparam logic [10:0] POOL_SIZE_RST = 11'd1024;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] lease_end;
    logic [15:0] owner;
    logic        owned;
  } entry_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic scan_init;
    logic scan_run;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic act;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/dlps_chan_if.sv =====
interface dlps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [29:0] now_time;
  logic [15:0] sender_id;
  logic [15:0] receiver_id;
  logic        to_broadcast;
  logic [15:0] requested_address;
  logic [30:0] requested_end;

  modport source (output valid, kind, now_time, sender_id, receiver_id, to_broadcast,
                  requested_address, requested_end, input ready);
  modport sink (input valid, kind, now_time, sender_id, receiver_id, to_broadcast,
                requested_address, requested_end, output ready);
endinterface

interface dlps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [15:0] dest_id;
  logic [15:0] address;
  logic [30:0] lease_end;

  modport source (output valid, reply_kind, dest_id, address, lease_end, input ready);
  modport sink (input valid, reply_kind, dest_id, address, lease_end, output ready);
endinterface

// ===== rtl/dhcp_lease_pool_server_core.sv =====
// Lease server over an address pool of POOL_DEPTH entries held in one single-port-write
// memory. After reset the pool is cleared one entry a cycle; until that ends no word is
// taken (configuration writes are). One word is handled at a time: an ignored message
// goes straight back to idle; a discover or request runs the single pass that reads,
// expires and writes back every entry of the active pool while searching for the address
// to offer or checking the requested one. A result waits in an output register, and the
// next word is taken meanwhile; that word's final write-back waits until the earlier
// result has been taken.
module dhcp_lease_pool_server_core #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dlps_pkg::CFG_DATA_W-1:0] cfg_data,
  dlps_in_if.sink                         in_ch,
  dlps_out_if.source                      out_ch
);
  import dlps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dlps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlps_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_data             (cfg_data),
    .in_kind              (in_ch.kind),
    .in_now_time          (in_ch.now_time),
    .in_sender_id         (in_ch.sender_id),
    .in_receiver_id       (in_ch.receiver_id),
    .in_to_broadcast      (in_ch.to_broadcast),
    .in_requested_address (in_ch.requested_address),
    .in_requested_end     (in_ch.requested_end),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_reply_kind       (out_ch.reply_kind),
    .out_dest_id          (out_ch.dest_id),
    .out_address          (out_ch.address),
    .out_lease_end        (out_ch.lease_end),
    .cmd                  (cmd),
    .sts                  (sts)
  );

endmodule

// ===== rtl/dlps_ctrl.sv =====
module dlps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dlps_pkg::sts_t sts,
  output dlps_pkg::cmd_t cmd
);
  import dlps_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LEASE1, S_LEASE2, S_SCAN, S_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_LEASE1;
      end
      S_LEASE1: begin
        cmd.scan_init = 1'b1;
        state_nxt = sts.act ? S_LEASE2 : S_IDLE;
      end
      S_LEASE2: state_nxt = S_SCAN;
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/dlps_datapath.sv =====
module dlps_datapath #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dlps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                      in_kind,
  input  logic [29:0]                     in_now_time,
  input  logic [15:0]                     in_sender_id,
  input  logic [15:0]                     in_receiver_id,
  input  logic                            in_to_broadcast,
  input  logic [15:0]                     in_requested_address,
  input  logic [30:0]                     in_requested_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_reply_kind,
  output logic [15:0]                     out_dest_id,
  output logic [15:0]                     out_address,
  output logic [30:0]                     out_lease_end,
  input  dlps_pkg::cmd_t                  cmd,
  output dlps_pkg::sts_t                  sts
);
  import dlps_pkg::*;

  localparam int AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW    = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = 17;

  logic [10:0] pool_size_r;
  logic [29:0] default_r, max_r, min_r;
  logic [15:0] server_r;

  logic [1:0]  kind_r;
  logic [29:0] now_r;
  logic [15:0] sender_r, recv_r, addr_r;
  logic        bcast_r;
  logic [30:0] req_end_r;

  logic signed [31:0] d_r;
  logic [29:0]        len_r;
  logic [30:0]        lease_r;
  logic signed [31:0] lo_c;
  logic [29:0]        len_c;

  logic [CW-1:0] n_c;
  logic [CW-1:0] cnt_r;
  logic          vld_r;
  logic [AW-1:0] wb_idx_r;
  entry_t        rd_data_r, e1, e2;
  entry_t        mem [POOL_DEPTH];

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic          rd_en;

  logic          own_f_r, free_f_r, exp_f_r, ok_r;
  logic [AW-1:0] own_i_r, free_i_r, exp_i_r, pick_c;
  logic          found_c, is_dis, to_self, in_range, expire, own_m;
  logic [15:0]   tgt_c;
  logic          produce;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [15:0]   out_dest_r, out_addr_r;
  logic [30:0]   out_lease_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= POOL_SIZE_RST;
      default_r   <= '0;
      max_r       <= '0;
      min_r       <= '0;
      server_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_POOL_SIZE:     pool_size_r <= cfg_data[10:0];
        CFG_DEFAULT_LEASE: default_r   <= cfg_data;
        CFG_MAX_LEASE:     max_r       <= cfg_data;
        CFG_MIN_LEASE:     min_r       <= cfg_data;
        CFG_SERVER_ID:     server_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CMP_W'(pool_size_r) >= CMP_W'(POOL_DEPTH)) n_c = CW'(POOL_DEPTH);
    else                                           n_c = CW'(pool_size_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      now_r     <= in_now_time;
      sender_r  <= in_sender_id;
      recv_r    <= in_receiver_id;
      bcast_r   <= in_to_broadcast;
      addr_r    <= in_requested_address;
      req_end_r <= in_requested_end;
    end
  end

  assign is_dis   = (kind_r == KIND_DIS);
  assign to_self  = (recv_r == server_r);
  assign sts.act  = (is_dis && bcast_r) || ((kind_r == KIND_REQ) && !bcast_r);
  assign tgt_c    = addr_r - 16'd1;
  assign in_range = (addr_r != 16'd0) && (CMP_W'(addr_r) <= CMP_W'(n_c));

  // lease length: three register steps, settled by the time the commit uses it
  always_comb begin
    lo_c  = (d_r > $signed({2'b00, min_r})) ? d_r : $signed({2'b00, min_r});
    len_c = (lo_c > $signed({2'b00, max_r})) ? max_r : lo_c[29:0];
  end

  always_ff @(posedge clk) begin
    d_r     <= $signed({1'b0, req_end_r}) - $signed({2'b00, now_r});
    len_r   <= len_c;
    lease_r <= (req_end_r == 31'd0) ? ({1'b0, now_r} + {1'b0, default_r})
                                    : ({1'b0, now_r} + {1'b0, len_r});
  end

  // expiry and release applied to the word read back
  always_comb begin
    e1     = rd_data_r;
    expire = (rd_data_r.lease_end != 31'd0) && (rd_data_r.lease_end <= {1'b0, now_r});
    if (expire) begin
      if (rd_data_r.status == ST_PEND) begin
        e1.status = ST_FREE;
        e1.owned  = 1'b0;
        e1.owner  = '0;
      end else if (rd_data_r.status == ST_OCC) begin
        e1.status = ST_EXP;
      end
      e1.lease_end = '0;
    end
    e2 = e1;
    if (!is_dis && !to_self && e1.owned && (e1.owner == sender_r) && (e1.status == ST_PEND))
    begin
      e2 = '0;
    end
    own_m = e2.owned && (e2.owner == sender_r);
  end

  assign rd_en = cmd.scan_run && (cnt_r != n_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (cmd.scan_init) cnt_r <= '0;
      else if (rd_en || cmd.clr_wr) cnt_r <= cnt_r + CW'(1);
      vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) wb_idx_r <= cnt_r[AW-1:0];
    if (cmd.scan_init) begin
      own_f_r  <= 1'b0;
      free_f_r <= 1'b0;
      exp_f_r  <= 1'b0;
      ok_r     <= 1'b0;
    end else if (vld_r) begin
      if (is_dis && own_m && !own_f_r) begin
        own_f_r <= 1'b1;
        own_i_r <= wb_idx_r;
      end
      if (is_dis && (e2.status == ST_FREE) && !free_f_r) begin
        free_f_r <= 1'b1;
        free_i_r <= wb_idx_r;
      end
      if (is_dis && (e2.status == ST_EXP) && !exp_f_r) begin
        exp_f_r <= 1'b1;
        exp_i_r <= wb_idx_r;
      end
      if (in_range && (16'(wb_idx_r) == tgt_c)) ok_r <= own_m;
    end
  end

  assign sts.clr_done  = (cnt_r == CW'(POOL_DEPTH - 1));
  assign sts.scan_done = (cnt_r == n_c) && !vld_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign found_c = own_f_r || free_f_r || exp_f_r;
  assign pick_c  = own_f_r ? own_i_r : (free_f_r ? free_i_r : exp_i_r);
  assign produce = cmd.commit && (is_dis ? found_c : to_self);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r[AW-1:0];
    mem_wd = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (vld_r) begin
      mem_we = 1'b1;
      mem_wa = wb_idx_r;
      mem_wd = e2;
    end else if (cmd.commit && is_dis && found_c) begin
      mem_we = 1'b1;
      mem_wa = pick_c;
      mem_wd = '{status: ST_PEND, lease_end: lease_r, owner: sender_r, owned: 1'b1};
    end else if (cmd.commit && !is_dis && to_self && ok_r) begin
      mem_we = 1'b1;
      mem_wa = tgt_c[AW-1:0];
      mem_wd = '{status: ST_OCC, lease_end: lease_r, owner: sender_r, owned: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  rd_data_r   <= mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_dest_r <= sender_r;
      if (is_dis) begin
        out_kind_r  <= REPLY_OFR;
        out_addr_r  <= 16'(pick_c) + 16'd1;
        out_lease_r <= lease_r;
      end else begin
        out_kind_r  <= ok_r ? REPLY_ACK : REPLY_NAK;
        out_addr_r  <= addr_r;
        out_lease_r <= ok_r ? lease_r : 31'd0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = out_kind_r;
  assign out_dest_id    = out_dest_r;
  assign out_address    = out_addr_r;
  assign out_lease_end  = out_lease_r;

  a_wb_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (CMP_W'(wb_idx_r) < CMP_W'(n_c)))
    else $error("write-back beyond active pool");

  a_commit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !vld_r)
    else $error("commit collides with scan write-back");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    produce |-> !(out_valid_r && !out_ready))
    else $error("result overwrites a word not yet taken");

endmodule
